@@ hw/rtl/indexed_insert_erase_array_core_macros.svh @@
// ----------------------------------------------------------------------------
// indexed insert/erase array assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_ERASE_ARRAY_CORE_MACROS_SVH
`define INDEXED_INSERT_ERASE_ARRAY_CORE_MACROS_SVH

// same-cycle implication
`define IIEA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IIEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/iiea_pkg.sv @@
// ----------------------------------------------------------------------------
// iiea_pkg
// types and constants shared by the indexed insert/erase array cells and core
// ----------------------------------------------------------------------------
package iiea_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int TYPE_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [TYPE_W-1:0] {
        REQ_READ   = 3'd0,
        REQ_WRITE  = 3'd1,
        REQ_APPEND = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_INSERT = 3'd4,
        REQ_ERASE  = 3'd5,
        REQ_FRONT  = 3'd6,
        REQ_BACK   = 3'd7
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // what every cell does in the coming cycle
    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_INS   = 2'd2,
        ACT_ERASE = 2'd3
    } cell_act_t;

    typedef struct packed {
        cell_act_t act;
        logic      rd_en;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/iiea_cell.sv @@
// ----------------------------------------------------------------------------
// iiea_cell
// one element slot of the array; loads, shifts up from its lower neighbour or
// down from its upper neighbour, and drives its word onto the read bus
// ----------------------------------------------------------------------------
module iiea_cell #(
    parameter int DATA_WIDTH = iiea_pkg::DATA_WIDTH_DEFAULT,
    parameter int IDX_WIDTH  = 6,
    parameter int CELL_INDEX = 0
) (
    input  logic                  clk,
    input  iiea_pkg::cell_ctrl_t  ctrl,
    input  logic [IDX_WIDTH-1:0]  idx,
    input  logic [IDX_WIDTH-1:0]  rd_idx,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] lower_data,
    input  logic [DATA_WIDTH-1:0] upper_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] rd_data
);

    localparam logic [IDX_WIDTH-1:0] MY_INDEX = IDX_WIDTH'(CELL_INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.act)
            iiea_pkg::ACT_HOLD:
            begin
                data_next = data_reg;
            end
            iiea_pkg::ACT_LOAD:
            begin
                if (MY_INDEX == idx)
                begin
                    data_next = wr_data;
                end
            end
            iiea_pkg::ACT_INS:
            begin
                if (MY_INDEX > idx)
                begin
                    data_next = lower_data;
                end
                else if (MY_INDEX == idx)
                begin
                    data_next = wr_data;
                end
            end
            iiea_pkg::ACT_ERASE:
            begin
                if (MY_INDEX >= idx)
                begin
                    data_next = upper_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (ctrl.rd_en && (rd_idx == MY_INDEX)) ? data_reg : '0;

endmodule

@@ hw/rtl/indexed_insert_erase_array_core.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_erase_array_core
// fixed-capacity ordered array held in a row of cells, with read, write,
// append, remove last, insert, erase, front and back requests
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_ready  | req_type, position, value
//  out     | out       | out_valid/out_ready| read_data, element_count, status
//
//  one item per cycle: each request is decoded and applied to every cell in
//  the cycle it is accepted, and its result sits in the output register next
//  cycle; insert and erase shift all cells at or above the position at once.
//  reset clears the element count and the output valid; cell contents are
//  undefined until written. no clearing pass.
//  in_ready drops only while a result waits and out_ready is low.
// ----------------------------------------------------------------------------
`include "indexed_insert_erase_array_core_macros.svh"

module indexed_insert_erase_array_core #(
    parameter int DEPTH      = iiea_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = iiea_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [iiea_pkg::TYPE_W-1:0]   req_type,
    input  logic [iiea_pkg::POS_W-1:0]    position,
    input  logic [iiea_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iiea_pkg::VALUE_W-1:0]  read_data,
    output logic [iiea_pkg::COUNT_W-1:0]  element_count,
    output logic [iiea_pkg::STATUS_W-1:0] status
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > iiea_pkg::POS_W) ? CW : iiea_pkg::POS_W;

    logic                          in_accept;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          out_valid_reg;
    logic [iiea_pkg::VALUE_W-1:0]  read_data_reg;
    logic [iiea_pkg::COUNT_W-1:0]  element_count_reg;
    iiea_pkg::status_t             status_reg;
    iiea_pkg::status_t             status_next;

    logic [CMPW-1:0]               pos_wide;
    logic [CMPW-1:0]               cnt_wide;
    logic                          in_range;
    logic                          ins_range;
    logic                          is_full;
    logic                          is_empty;
    logic [IW-1:0]                 pos_idx;
    logic [IW-1:0]                 cnt_idx;
    logic [IW-1:0]                 last_idx;

    iiea_pkg::cell_act_t           act;
    logic                          rd_en;
    iiea_pkg::cell_ctrl_t          ctrl;
    logic [IW-1:0]                 idx;
    logic [IW-1:0]                 rd_idx;
    logic [DATA_WIDTH-1:0]         wr_data;
    logic [DATA_WIDTH-1:0]         rd_or;
    logic [iiea_pkg::VALUE_W-1:0]  rd_word;

    logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]         cell_rd   [DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign pos_wide  = CMPW'(position);
    assign cnt_wide  = CMPW'(count_reg);
    assign in_range  = pos_wide < cnt_wide;
    assign ins_range = pos_wide <= cnt_wide;
    assign is_full   = count_reg == CW'(DEPTH);
    assign is_empty  = count_reg == '0;
    assign pos_idx   = pos_wide[IW-1:0];
    assign cnt_idx   = count_reg[IW-1:0];
    assign last_idx  = cnt_idx - 1'b1;

    generate
        if (DATA_WIDTH <= iiea_pkg::VALUE_W)
        begin : g_narrow
            assign wr_data = value[DATA_WIDTH-1:0];
            assign rd_word = iiea_pkg::VALUE_W'(rd_or);
        end
        else
        begin : g_wide
            assign wr_data = DATA_WIDTH'(value);
            assign rd_word = rd_or[iiea_pkg::VALUE_W-1:0];
        end
    endgenerate

    // request decode
    always_comb
    begin
        act         = iiea_pkg::ACT_HOLD;
        rd_en       = 1'b0;
        idx         = pos_idx;
        rd_idx      = pos_idx;
        status_next = iiea_pkg::ST_OK;
        count_next  = count_reg;
        unique case (iiea_pkg::req_type_t'(req_type))
            iiea_pkg::REQ_READ:
            begin
                if (!in_range)
                begin
                    status_next = iiea_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            iiea_pkg::REQ_WRITE:
            begin
                if (!in_range)
                begin
                    status_next = iiea_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    act = iiea_pkg::ACT_LOAD;
                end
            end
            iiea_pkg::REQ_APPEND:
            begin
                if (is_full)
                begin
                    status_next = iiea_pkg::ST_FULL;
                end
                else
                begin
                    act        = iiea_pkg::ACT_LOAD;
                    idx        = cnt_idx;
                    count_next = count_reg + 1'b1;
                end
            end
            iiea_pkg::REQ_REMOVE:
            begin
                if (is_empty)
                begin
                    status_next = iiea_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            iiea_pkg::REQ_INSERT:
            begin
                if (!ins_range)
                begin
                    status_next = iiea_pkg::ST_BAD_INDEX;
                end
                else if (is_full)
                begin
                    status_next = iiea_pkg::ST_FULL;
                end
                else
                begin
                    act        = iiea_pkg::ACT_INS;
                    count_next = count_reg + 1'b1;
                end
            end
            iiea_pkg::REQ_ERASE:
            begin
                if (!in_range)
                begin
                    status_next = iiea_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    act        = iiea_pkg::ACT_ERASE;
                    count_next = count_reg - 1'b1;
                end
            end
            iiea_pkg::REQ_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = iiea_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en  = 1'b1;
                    rd_idx = '0;
                end
            end
            iiea_pkg::REQ_BACK:
            begin
                if (is_empty)
                begin
                    status_next = iiea_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en  = 1'b1;
                    rd_idx = last_idx;
                end
            end
            default:
            begin
                status_next = iiea_pkg::ST_OK;
            end
        endcase
    end

    assign ctrl.act   = in_accept ? act : iiea_pkg::ACT_HOLD;
    assign ctrl.rd_en = rd_en;

    // row of cells
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] lower;
            logic [DATA_WIDTH-1:0] upper;

            if (i == 0)
            begin : g_first
                assign lower = wr_data;
            end
            else
            begin : g_mid_lo
                assign lower = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign upper = cell_data[i];
            end
            else
            begin : g_mid_hi
                assign upper = cell_data[i+1];
            end

            iiea_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX_WIDTH  (IW),
                .CELL_INDEX (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (idx),
                .rd_idx     (rd_idx),
                .wr_data    (wr_data),
                .lower_data (lower),
                .upper_data (upper),
                .data       (cell_data[i]),
                .rd_data    (cell_rd[i])
            );
        end
    endgenerate

    // read bus
    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            read_data_reg     <= rd_word;
            element_count_reg <= iiea_pkg::COUNT_W'(count_next);
            status_reg        <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign element_count = element_count_reg;
    assign status        = status_reg;

    `IIEA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "count above depth")
    `IIEA_ASSERT_NEXT(a_count_hold, !in_accept, $stable(count_reg), "count moved without item")
    `IIEA_ASSERT_NEXT(a_count_step, in_accept, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1), "count moved by more than one")
    `IIEA_ASSERT_NEXT(a_result_shown, in_accept, out_valid_reg, "accepted item gave no result")
    `IIEA_ASSERT_NOW(a_error_zero, out_valid_reg && (status_reg != iiea_pkg::ST_OK), read_data_reg == '0, "read data not zero on error")

endmodule

@@ tb/indexed_insert_erase_array_core_tb.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_erase_array_core_tb
// drives read, write, append, remove last, insert, erase, front and back
// requests into the array core and checks every result against typed-in values
// or a shadow copy of the array kept in the bench: first a table of directed
// requests, then random requests that repeatedly grow the array to full and
// drain it empty, with random idling on both channels and one long output stall
// ----------------------------------------------------------------------------
module indexed_insert_erase_array_core_tb;
    import iiea_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int CLK_PERIOD   = 10;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 1925;
    localparam int QUIET_TAIL   = 300;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [VALUE_W-1:0] rd;
        logic [COUNT_W-1:0] cnt;
        status_t            st;
    } arr_result_t;

    typedef struct {
        req_type_t          op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        logic [VALUE_W-1:0] rd;
        logic [COUNT_W-1:0] cnt;
        status_t            st;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [TYPE_W-1:0]   req_type;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  value;
    logic                out_valid;
    logic                out_ready;
    logic [VALUE_W-1:0]  read_data;
    logic [COUNT_W-1:0]  element_count;
    logic [STATUS_W-1:0] status;

    logic [VALUE_W-1:0] shadow_words [DEPTH];
    int                 shadow_count;
    arr_result_t        pending_results [$];

    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    int cycle_count;
    int items_sent;
    int results_checked;
    int mismatches;
    int full_seen;
    int empty_seen;
    int bad_index_seen;
    int full_array_reached;

    // directed requests; expected values typed in where obvious, else predicted
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{REQ_READ,   6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, ST_BAD_INDEX},
        '{REQ_WRITE,  6'd0,  32'h0000_1234, 1'b1, 32'h0, 7'd0, ST_BAD_INDEX},
        '{REQ_ERASE,  6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, ST_BAD_INDEX},
        '{REQ_REMOVE, 6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, ST_EMPTY},
        '{REQ_FRONT,  6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, ST_EMPTY},
        '{REQ_BACK,   6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, ST_EMPTY},
        '{REQ_INSERT, 6'd1,  32'hdead_beef, 1'b1, 32'h0, 7'd0, ST_BAD_INDEX},
        '{REQ_INSERT, 6'd0,  32'hffff_ffff, 1'b1, 32'h0, 7'd1, ST_OK},
        '{REQ_APPEND, 6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd2, ST_OK},
        '{REQ_READ,   6'd0,  32'h0000_0000, 1'b1, 32'hffff_ffff, 7'd2, ST_OK},
        '{REQ_READ,   6'd1,  32'h0000_0000, 1'b1, 32'h0, 7'd2, ST_OK},
        '{REQ_READ,   6'd2,  32'h0000_0000, 1'b1, 32'h0, 7'd2, ST_BAD_INDEX},
        '{REQ_INSERT, 6'd2,  32'ha5a5_a5a5, 1'b1, 32'h0, 7'd3, ST_OK},
        '{REQ_INSERT, 6'd1,  32'h5a5a_5a5a, 1'b1, 32'h0, 7'd4, ST_OK},
        '{REQ_WRITE,  6'd3,  32'h1234_5678, 1'b0, 32'h0, 7'd0, ST_OK},
        '{REQ_BACK,   6'd0,  32'h0000_0000, 1'b0, 32'h0, 7'd0, ST_OK},
        '{REQ_ERASE,  6'd0,  32'h0000_0000, 1'b0, 32'h0, 7'd0, ST_OK},
        '{REQ_FRONT,  6'd0,  32'h0000_0000, 1'b0, 32'h0, 7'd0, ST_OK},
        '{REQ_ERASE,  6'd63, 32'h0000_0000, 1'b1, 32'h0, 7'd3, ST_BAD_INDEX},
        '{REQ_READ,   6'd63, 32'h0000_0000, 1'b1, 32'h0, 7'd3, ST_BAD_INDEX},
        '{REQ_WRITE,  6'd63, 32'hffff_ffff, 1'b1, 32'h0, 7'd3, ST_BAD_INDEX},
        '{REQ_INSERT, 6'd63, 32'hffff_ffff, 1'b1, 32'h0, 7'd3, ST_BAD_INDEX},
        '{REQ_REMOVE, 6'd0,  32'h0000_0000, 1'b0, 32'h0, 7'd0, ST_OK},
        '{REQ_ERASE,  6'd1,  32'h0000_0000, 1'b0, 32'h0, 7'd0, ST_OK},
        '{REQ_ERASE,  6'd0,  32'h0000_0000, 1'b0, 32'h0, 7'd0, ST_OK}
    };

    indexed_insert_erase_array_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .element_count (element_count),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow array update; returns what the block should answer
    function automatic arr_result_t apply_request(req_type_t op, logic [POS_W-1:0] pos,
                                                  logic [VALUE_W-1:0] val);
        arr_result_t r;
        int          j;
        r.rd = '0;
        r.st = ST_OK;
        case (op)
            REQ_READ:
            begin
                if (pos >= shadow_count)
                    r.st = ST_BAD_INDEX;
                else
                    r.rd = shadow_words[pos];
            end
            REQ_WRITE:
            begin
                if (pos >= shadow_count)
                    r.st = ST_BAD_INDEX;
                else
                    shadow_words[pos] = val;
            end
            REQ_APPEND:
            begin
                if (shadow_count >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    shadow_words[shadow_count] = val;
                    shadow_count++;
                end
            end
            REQ_REMOVE:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else
                    shadow_count--;
            end
            REQ_INSERT:
            begin
                if (pos > shadow_count)
                    r.st = ST_BAD_INDEX;
                else if (shadow_count >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    for (j = shadow_count; j > pos; j--)
                        shadow_words[j] = shadow_words[j - 1];
                    shadow_words[pos] = val;
                    shadow_count++;
                end
            end
            REQ_ERASE:
            begin
                if (pos >= shadow_count)
                    r.st = ST_BAD_INDEX;
                else
                begin
                    for (j = pos; j + 1 < shadow_count; j++)
                        shadow_words[j] = shadow_words[j + 1];
                    shadow_count--;
                end
            end
            REQ_FRONT:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else
                    r.rd = shadow_words[0];
            end
            default:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else
                    r.rd = shadow_words[shadow_count - 1];
            end
        endcase
        r.cnt = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(req_type_t op, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] val, bit typed, arr_result_t typed_res);
        arr_result_t r;
        arr_result_t exp_res;
        int          prev_count;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        prev_count = shadow_count;
        r = apply_request(op, pos, val);
        if (shadow_count == DEPTH && prev_count != DEPTH)
            full_array_reached++;
        exp_res = typed ? typed_res : r;
        pending_results.insert(pending_results.size(), exp_res);
        items_sent++;
        @(negedge clk);
    endtask

    // result checking
    always @(posedge clk)
    begin
        arr_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: read_data %h count %0d status %0d",
                             read_data, element_count, status);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                case (want.st)
                    ST_FULL:      full_seen++;
                    ST_EMPTY:     empty_seen++;
                    ST_BAD_INDEX: bad_index_seen++;
                    default:      ;
                endcase
                if (read_data !== want.rd || element_count !== want.cnt
                    || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch on result %0d: read_data %h/%h",
                                  " count %0d/%0d status %0d/%0d (want/got)"},
                                 results_checked, want.rd, read_data, want.cnt,
                                 element_count, want.st, status);
                end
            end
        end
    end

    // receiver side: short random stalls, and one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL indexed_insert_erase_array_core");
            $finish;
        end
    end

    initial
    begin
        arr_result_t        typed_res;
        req_type_t          op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        bit                 grow_phase;
        int                 pick;
        int                 i;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        position = '0;
        value    = '0;
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 1'b0;
        shadow_count = 0;
        grow_phase   = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (i = 0; i < N_DIRECTED; i++)
        begin
            typed_res.rd  = directed_rows[i].rd;
            typed_res.cnt = directed_rows[i].cnt;
            typed_res.st  = directed_rows[i].st;
            send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                         directed_rows[i].typed, typed_res);
        end

        // random requests, mostly well formed, swinging between full and empty
        for (i = 0; i < N_RANDOM; i++)
        begin
            tx_idle = (i < N_RANDOM - QUIET_TAIL) && ((i / 150) % 2 == 0);
            rx_idle = (i < N_RANDOM - QUIET_TAIL) && (((i + 75) / 150) % 2 == 0);
            if (i == 400)
                hold_req = 1'b1;
            if (shadow_count == DEPTH)
                grow_phase = 1'b0;
            else if (shadow_count == 0)
                grow_phase = 1'b1;

            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase

            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any type, any index
                op  = req_type_t'($urandom_range(0, 7));
                pos = POS_W'($urandom_range(0, 63));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    op = REQ_READ;
                else if (pick < 30)
                    op = REQ_WRITE;
                else if (pick < 35)
                    op = REQ_FRONT;
                else if (pick < 40)
                    op = REQ_BACK;
                else if (pick < 70)
                    op = grow_phase ? REQ_APPEND : REQ_REMOVE;
                else
                    op = grow_phase ? REQ_INSERT : REQ_ERASE;
                if (op == REQ_INSERT)
                    pos = (shadow_count >= DEPTH) ? POS_W'($urandom_range(0, DEPTH - 1))
                                                  : POS_W'($urandom_range(0, shadow_count));
                else if (shadow_count > 0)
                    pos = POS_W'($urandom_range(0, shadow_count - 1));
                else
                    pos = POS_W'($urandom_range(0, 63));
            end
            send_request(op, pos, val, 1'b0, typed_res);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked, array filled %0d times",
                 items_sent, results_checked, full_array_reached);
        $display("error answers seen: %0d bad index, %0d full, %0d empty",
                 bad_index_seen, full_seen, empty_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS indexed_insert_erase_array_core");
        else
            $display("FAIL indexed_insert_erase_array_core");
        $finish;
    end

endmodule
